/* rtl/vfp_pkg.sv */
`default_nettype none

package vfp_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_OUT_MAX   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OUT_MIN   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_STOP_BAND = 3'd5;

  localparam logic [31:0] OUT_MAX_RESET   = 32'h7FFF_FFFF;
  localparam logic [31:0] OUT_MIN_RESET   = 32'h0000_0000;
  localparam logic [31:0] GAIN_RESET      = 32'h0000_0000;
  localparam logic [30:0] STOP_BAND_RESET = 31'd983040;

  typedef struct packed {
    logic signed [31:0] setpoint;
    logic signed [31:0] measurement;
  } in_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               held;
  } out_t;

  typedef struct packed {
    logic signed [31:0] out_max;
    logic signed [31:0] out_min;
    logic signed [31:0] gain_p;
    logic signed [31:0] gain_i;
    logic signed [31:0] gain_d;
    logic        [30:0] stop_band;
  } cfg_t;

  typedef struct packed {
    logic               held;
    logic signed [32:0] err;
    logic signed [32:0] dm;
  } work_t;

endpackage

`default_nettype wire

/* rtl/velocity_form_pid_step.sv */
`default_nettype none

// Incremental PID step with output clamp, values signed Q16.16 (stop_band is
// unsigned). One word in (setpoint, measurement) gives one word out (drive,
// held). A zero setpoint with the measurement magnitude below stop_band returns
// drive 0 with held set and leaves the stored measurement and drive untouched.
// Otherwise the drive is the previous drive (out_min when that is zero) plus the
// proportional-integral and derivative terms, saturated to 32 bits and clamped
// to out_max, then out_min. Sustained rate is one word per clock while out_ready
// stays high. The rate is set by the combinational loop that adds both terms to
// the stored drive and clamps it. The front end classifies words and forms the
// error terms into a short queue; the back end multiplies in one stage and
// accumulates in the next. Write registers only while idle.
module velocity_form_pid_step #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  vfp_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  wire                                out_ready,
  output vfp_pkg::out_t                      out_data,
  input  wire                                cfg_we,
  input  wire  [vfp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire  [vfp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import vfp_pkg::*;

  cfg_t  cfg;
  logic  push;
  logic  push_ready;
  work_t push_data;
  logic  pop_valid;
  logic  pop;
  work_t pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.out_max   <= OUT_MAX_RESET;
      cfg.out_min   <= OUT_MIN_RESET;
      cfg.gain_p    <= GAIN_RESET;
      cfg.gain_i    <= GAIN_RESET;
      cfg.gain_d    <= GAIN_RESET;
      cfg.stop_band <= STOP_BAND_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OUT_MAX:   cfg.out_max   <= cfg_data;
        REG_OUT_MIN:   cfg.out_min   <= cfg_data;
        REG_GAIN_P:    cfg.gain_p    <= cfg_data;
        REG_GAIN_I:    cfg.gain_i    <= cfg_data;
        REG_GAIN_D:    cfg.gain_d    <= cfg_data;
        REG_STOP_BAND: cfg.stop_band <= cfg_data[30:0];
        default: begin
        end
      endcase
    end
  end

  vfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .stop_band (cfg.stop_band),
    .q_ready   (push_ready),
    .q_push    (push),
    .q_data    (push_data)
  );

  vfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_data   (pop_data)
  );

  vfp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (pop_valid),
    .q_pop     (pop),
    .q_data    (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* rtl/vfp_front.sv */
`default_nettype none

module vfp_front (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  vfp_pkg::in_t      in_data,
  input  wire  [30:0]       stop_band,
  input  wire               q_ready,
  output logic              q_push,
  output vfp_pkg::work_t    q_data
);
  import vfp_pkg::*;

  logic signed [31:0] prev_measurement;
  logic        [31:0] mag;
  logic               held;

  always_comb begin
    mag = in_data.measurement[31] ? 32'(-in_data.measurement)
                                  : 32'(in_data.measurement);
    held = (in_data.setpoint == 32'sd0) && (mag < {1'b0, stop_band});
    q_data.held = held;
    q_data.err  = {in_data.setpoint[31], in_data.setpoint}
                - {in_data.measurement[31], in_data.measurement};
    q_data.dm   = {prev_measurement[31], prev_measurement}
                - {in_data.measurement[31], in_data.measurement};
  end

  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_measurement <= '0;
    end else if (q_push && !held) begin
      prev_measurement <= in_data.measurement;
    end
  end

endmodule

`default_nettype wire

/* rtl/vfp_queue.sv */
`default_nettype none

module vfp_queue #(
  parameter int DEPTH = 2
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             push,
  output logic            push_ready,
  input  vfp_pkg::work_t  push_data,
  output logic            pop_valid,
  input  wire             pop,
  output vfp_pkg::work_t  pop_data
);
  import vfp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  work_t             slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/vfp_back.sv */
`default_nettype none

module vfp_back (
  input  wire             clk,
  input  wire             rst,
  input  vfp_pkg::cfg_t   cfg,
  input  wire             q_valid,
  output logic            q_pop,
  input  vfp_pkg::work_t  q_data,
  output logic            out_valid,
  input  wire             out_ready,
  output vfp_pkg::out_t   out_data
);
  import vfp_pkg::*;

  localparam logic signed [51:0] SUM_MAX = 52'sd2147483647;
  localparam logic signed [51:0] SUM_MIN = -52'sd2147483648;

  logic               s1_valid;
  logic               s1_held;
  logic signed [49:0] s1_pi;
  logic signed [48:0] s1_d;
  logic signed [31:0] prev_drive;

  logic               s1_adv;
  logic               s2_adv;
  logic signed [32:0] gain_sum;
  logic signed [65:0] prod_pi;
  logic signed [64:0] prod_d;
  logic signed [31:0] base;
  logic signed [51:0] sum;
  logic signed [31:0] sat;
  logic signed [31:0] hi_clamped;
  logic signed [31:0] drive_next;

  assign s2_adv = !out_valid || out_ready;
  assign s1_adv = !s1_valid || s2_adv;
  assign q_pop  = q_valid && s1_adv;

  always_comb begin
    gain_sum = {cfg.gain_p[31], cfg.gain_p} + {cfg.gain_i[31], cfg.gain_i};
    prod_pi  = gain_sum * q_data.err;
    prod_d   = 33'(cfg.gain_d) * q_data.dm;
  end

  always_comb begin
    base = (prev_drive == 32'sd0) ? cfg.out_min : prev_drive;
    sum  = {{20{base[31]}}, base} + {{2{s1_pi[49]}}, s1_pi}
         + {{3{s1_d[48]}}, s1_d};
    if (sum > SUM_MAX) begin
      sat = 32'(SUM_MAX);
    end else if (sum < SUM_MIN) begin
      sat = 32'(SUM_MIN);
    end else begin
      sat = sum[31:0];
    end
    hi_clamped = (sat > cfg.out_max) ? cfg.out_max : sat;
    drive_next = (hi_clamped < cfg.out_min) ? cfg.out_min : hi_clamped;
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_held <= q_data.held;
      s1_pi   <= prod_pi[65:16];
      s1_d    <= prod_d[64:16];
    end
    if (s1_valid && s2_adv) begin
      out_data.held  <= s1_held;
      out_data.drive <= s1_held ? 32'sd0 : drive_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
      prev_drive <= '0;
    end else begin
      if (s1_adv) begin
        s1_valid <= q_valid;
      end
      if (s2_adv) begin
        out_valid <= s1_valid;
      end
      if (s1_valid && s2_adv && !s1_held) begin
        prev_drive <= drive_next;
      end
    end
  end

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import vfp_pkg::*;

  typedef enum logic [1:0] {ROW_CFG, ROW_ITEM, ROW_KNOWN} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  value;
    in_t                    word;
    out_t                   known;
  } stim_row_t;

  localparam int     PHASES      = 9;
  localparam int     PHASE_ITEMS = 200;
  localparam longint SAT_HI      = 64'sd2147483647;
  localparam longint SAT_LO      = -64'sd2147483648;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_t                    in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_t                   out_data;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  logic                   word_known = 1'b0;
  out_t                   word_expect = '0;

  logic signed [31:0]     lim_hi, lim_lo, kp, ki, kd;
  logic        [30:0]     band;
  logic signed [31:0]     last_meas, last_drive;

  out_t                   drive_due[$];
  out_t                   fresh, oldest;
  stim_row_t              rows[$];
  int                     fails = 0;
  int                     send_gap_pct = 38;
  int                     recv_stall_pct = 62;

  velocity_form_pid_step dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic out_t predict_drive(in_t w);
    logic signed [32:0] ms_wide, mag, gsum, err, dm;
    logic signed [65:0] pi_prod, d_prod;
    logic signed [67:0] total;
    logic signed [31:0] base;
    out_t               r;
    ms_wide = $signed(w.measurement);
    mag = ms_wide[32] ? -ms_wide : ms_wide;
    if ($signed(w.setpoint) == 0 && $unsigned(mag) < {2'b00, band}) begin
      r.drive = '0;
      r.held  = 1'b1;
    end else begin
      base    = (last_drive == 0) ? lim_lo : last_drive;
      gsum    = kp + ki;
      err     = $signed(w.setpoint) - $signed(w.measurement);
      dm      = last_meas - $signed(w.measurement);
      pi_prod = gsum * err;
      d_prod  = kd * dm;
      total   = base + (pi_prod >>> 16) + (d_prod >>> 16);
      if (total > SAT_HI) total = SAT_HI;
      if (total < SAT_LO) total = SAT_LO;
      if (total > lim_hi) total = lim_hi;
      if (total < lim_lo) total = lim_lo;
      last_meas  = $signed(w.measurement);
      last_drive = total[31:0];
      r.drive    = total[31:0];
      r.held     = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      lim_hi     <= OUT_MAX_RESET;
      lim_lo     <= OUT_MIN_RESET;
      kp         <= GAIN_RESET;
      ki         <= GAIN_RESET;
      kd         <= GAIN_RESET;
      band       <= STOP_BAND_RESET;
      last_meas  <= '0;
      last_drive <= '0;
    end else begin
      if (in_valid && in_ready) begin
        fresh = predict_drive(in_data);
        drive_due.push_back(word_known ? word_expect : fresh);
      end
      if (out_valid && out_ready) begin
        if (drive_due.size() == 0) begin
          fails++;
          $display("%0t unexpected word: expected none, got drive %h held %b",
                   $time, out_data.drive, out_data.held);
        end else begin
          oldest = drive_due.pop_front();
          if (out_data.drive !== oldest.drive || out_data.held !== oldest.held) begin
            fails++;
            $display("%0t mismatch: expected drive %h held %b, got drive %h held %b",
                     $time, oldest.drive, oldest.held, out_data.drive, out_data.held);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_OUT_MAX:   lim_hi <= cfg_data;
          REG_OUT_MIN:   lim_lo <= cfg_data;
          REG_GAIN_P:    kp     <= cfg_data;
          REG_GAIN_I:    ki     <= cfg_data;
          REG_GAIN_D:    kd     <= cfg_data;
          REG_STOP_BAND: band   <= cfg_data[30:0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_word(in_t w, bit known, out_t ex);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_data     <= w;
    word_known  <= known;
    word_expect <= ex;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (drive_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic row_cfg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
    stim_row_t r;
    r.kind  = ROW_CFG;
    r.index = idx;
    r.value = val;
    r.word  = '0;
    r.known = '0;
    rows.push_back(r);
  endtask

  task automatic row_item(logic [31:0] sp, logic [31:0] ms);
    stim_row_t r;
    r.kind             = ROW_ITEM;
    r.index            = '0;
    r.value            = '0;
    r.word.setpoint    = sp;
    r.word.measurement = ms;
    r.known            = '0;
    rows.push_back(r);
  endtask

  task automatic row_known(logic [31:0] sp, logic [31:0] ms, logic [31:0] d, logic h);
    stim_row_t r;
    r.kind             = ROW_KNOWN;
    r.index            = '0;
    r.value            = '0;
    r.word.setpoint    = sp;
    r.word.measurement = ms;
    r.known.drive      = d;
    r.known.held       = h;
    rows.push_back(r);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3, 4:    return $urandom;
      default: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return $urandom;
      default: return $urandom_range(32'h0002_0000) - 32'h0001_0000;
    endcase
  endfunction

  function automatic in_t pick_word();
    in_t         w;
    logic [31:0] m;
    w.setpoint = ($urandom_range(3) == 0) ? 32'h0 : pick_value();
    if ($urandom_range(2) == 0) begin
      m = {1'b0, band} + $urandom_range(8) - 32'd4;
      if ($urandom_range(1)) m = -m;
    end else begin
      m = pick_value();
    end
    w.measurement = m;
    return w;
  endfunction

  task automatic program_phase(int p);
    logic [31:0] hi, lo, t;
    settle();
    hi = $urandom;
    lo = $urandom;
    if ($signed(lo) > $signed(hi)) begin
      t  = hi;
      hi = lo;
      lo = t;
    end
    case (p)
      0: begin
        hi = 32'h7FFF_FFFF;
        lo = 32'h8000_0000;
      end
      3: begin
        t  = hi;
        hi = lo;
        lo = t;
      end
      4: begin
        hi = {1'b0, hi[30:0]};
        lo = 32'h0;
      end
      default: ;
    endcase
    put_reg(REG_OUT_MAX, hi);
    put_reg(REG_OUT_MIN, lo);
    put_reg(REG_GAIN_P, (p == 5) ? 32'h7FFF_FFFF : pick_gain());
    put_reg(REG_GAIN_I, (p == 5) ? 32'h7FFF_FFFF : pick_gain());
    put_reg(REG_GAIN_D, (p == 5) ? 32'h8000_0000 : pick_gain());
    case (p)
      2:       put_reg(REG_STOP_BAND, 32'h0);
      5:       put_reg(REG_STOP_BAND, 32'hFFFF_FFFF);
      6:       put_reg(REG_STOP_BAND, $urandom);
      default: put_reg(REG_STOP_BAND, $urandom & 32'h801F_FFFF);
    endcase
    cfg_we <= 1'b0;
  endtask

  initial begin
    row_known(32'h0, 32'h0, 32'h0, 1'b1);
    row_known(32'h0, 32'd983039, 32'h0, 1'b1);
    row_known(32'h0, 32'd983040, 32'h0, 1'b0);
    row_known(32'h0, -32'sd983039, 32'h0, 1'b1);
    row_known(32'h0, -32'sd983040, 32'h0, 1'b0);
    row_known(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0);
    row_known(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0);
    row_known(32'h0001_0000, 32'h0001_0000, 32'h0, 1'b0);
    row_cfg(REG_GAIN_P, 32'h7FFF_FFFF);
    row_cfg(REG_GAIN_I, 32'h7FFF_FFFF);
    row_cfg(REG_GAIN_D, 32'h8000_0000);
    row_item(32'h7FFF_FFFF, 32'h8000_0000);
    row_item(32'h8000_0000, 32'h7FFF_FFFF);
    row_item(32'h8000_0000, 32'h8000_0000);
    row_cfg(REG_OUT_MAX, 32'h8000_0000);
    row_cfg(REG_OUT_MIN, 32'h7FFF_FFFF);
    row_known(32'h1234_5678, 32'h0, 32'h7FFF_FFFF, 1'b0);
    row_known(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    row_known(32'h0, 32'h0, 32'h0, 1'b1);
    row_cfg(REG_OUT_MAX, 32'h0);
    row_cfg(REG_OUT_MIN, 32'h0);
    row_cfg(REG_GAIN_P, 32'h0);
    row_cfg(REG_GAIN_I, 32'h0);
    row_cfg(REG_GAIN_D, 32'h0);
    row_known(32'd5, 32'd5, 32'h0, 1'b0);
    row_cfg(REG_OUT_MAX, 32'h7FFF_FFFF);
    row_cfg(REG_OUT_MIN, 32'h0003_0000);
    row_known(32'd5, 32'd5, 32'h0003_0000, 1'b0);
    row_cfg(REG_OUT_MIN, 32'h8000_0000);
    row_known(32'd7, 32'd7, 32'h0003_0000, 1'b0);
    row_cfg(REG_GAIN_P, 32'h1);
    row_item(32'd1, 32'd2);
    row_item(32'd3, 32'd2);
    row_cfg(REG_GAIN_D, 32'h0001_0000);
    row_item(32'h100, -32'sh50000);
    row_cfg(REG_STOP_BAND, 32'h0);
    row_item(32'h0, 32'h0);
    row_cfg(REG_STOP_BAND, 32'hFFFF_FFFF);
    row_item(32'h0, 32'h8000_0000);
    row_known(32'h0, 32'h7FFF_FFFE, 32'h0, 1'b1);
    row_item(32'h0, 32'h7FFF_FFFF);
    row_item(32'h0, -32'sh7FFF_FFFF);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        if (!cfg_we) settle();
        put_reg(rows[i].index, rows[i].value);
      end else begin
        if (cfg_we) cfg_we <= 1'b0;
        send_word(rows[i].word, rows[i].kind == ROW_KNOWN, rows[i].known);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      program_phase(p);
      case (p / 3)
        0: begin
          send_gap_pct   = 38;
          recv_stall_pct = 62;
        end
        1: begin
          send_gap_pct   = 62;
          recv_stall_pct = 38;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // hold off until the pipeline drains
        if (k == PHASE_ITEMS / 2 && p % 2 == 0) settle();
        send_word(pick_word(), 1'b0, '0);
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (fails == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
